// ----- rtl/packet_byte_rate_limiter_core_macros.svh -----
// Assertion macros used by the rate limiter engine.
`ifndef PACKET_BYTE_RATE_LIMITER_CORE_MACROS_SVH
`define PACKET_BYTE_RATE_LIMITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBRL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("pbrl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("pbrl assertion failed");

`endif

// ----- rtl/pbrl_pkg.sv -----
// Types and constants shared by the packet byte-rate limiter modules.
package pbrl_pkg;

	localparam int TIME_W = 64;
	localparam int BT_W   = 20;
	localparam int WAIT_W = 32;

	localparam logic [BT_W-1:0] BT_RESET = 20'd1000000;

	localparam logic OP_SEND    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUDGET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL1,
		ST_MUL2,
		ST_DIV2,
		ST_DUE,
		ST_DIFF,
		ST_CMP,
		ST_MOVE,
		ST_ADD,
		ST_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic taken;
	} eng_ctrl_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic              allowed;
		logic [WAIT_W-1:0] wait_us;
	} eng_stat_t;

endpackage

// ----- rtl/pbrl_if.sv -----
// Request and response channel interfaces of the packet byte-rate limiter.
interface pbrl_req_if #(
	parameter int LEN_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [pbrl_pkg::TIME_W-1:0] now_us;
	logic [LEN_BITS-1:0]        pkt_len;

	modport source (output valid, output operation, output now_us, output pkt_len,
		input ready);
	modport sink (input valid, input operation, input now_us, input pkt_len,
		output ready);
endinterface

interface pbrl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        allowed;
	logic [pbrl_pkg::WAIT_W-1:0] wait_us;

	modport source (output valid, output allowed, output wait_us, input ready);
	modport sink (input valid, input allowed, input wait_us, output ready);
endinterface

// ----- rtl/packet_byte_rate_limiter_core.sv -----
// Top level of the packet byte-rate limiter: channels, configuration and result register.
//
// Usage: each request on the req channel either asks to send a packet
// (operation = send, with the current time now_us and pkt_len) or restarts
// the byte-budget window at now_us. Exactly one result per request leaves
// on the rsp channel: allowed, and wait_us in whole microseconds when the
// packet is refused. Both channels use a valid/ready handshake.
// The block works on one request at a time. A restart, a zero budget, an
// unlimited budget and a send while the budget is not yet spent skip the
// divide and multiply steps. Once the budget is spent the due time takes
// two restoring divisions and two shift-add multiplications on one shared
// adder, one bit per cycle; an admitted packet then also slides the window
// and adds its length. The next request is taken in the cycle after the
// result is handed over.
// The result register frees the sequencer, so a new request is accepted
// while the previous result still waits for a stalled receiver; the next
// result then waits in the sequencer until the register is emptied.
// Reset clears the window start, byte count, full flag and the response
// valid flag; the budget resets to zero and the block time to one second.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while no request is in flight; the block does not enforce it.
module packet_byte_rate_limiter_core #(
	parameter int LEN_BITS    = 16,
	parameter int BUDGET_BITS = 32,
	localparam int CFG_W      = (BUDGET_BITS > pbrl_pkg::BT_W) ? BUDGET_BITS : pbrl_pkg::BT_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pbrl_req_if.sink                       req,
	pbrl_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [pbrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]               cfg_data
);

	logic [BUDGET_BITS-1:0]        bpb_q;
	logic [pbrl_pkg::BT_W-1:0]     bt_q;
	logic                          rsp_valid_q;
	logic                          rsp_allowed_q;
	logic [pbrl_pkg::WAIT_W-1:0]   rsp_wait_q;
	logic                          load;
	pbrl_pkg::eng_ctrl_t           ctrl;
	pbrl_pkg::eng_stat_t           stat;

	// Configuration registers; writes are registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpb_q <= '0;
			bt_q  <= pbrl_pkg::BT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pbrl_pkg::CFG_IDX_BUDGET: bpb_q <= cfg_data[BUDGET_BITS-1:0];
				pbrl_pkg::CFG_IDX_BLOCK:  bt_q  <= cfg_data[pbrl_pkg::BT_W-1:0];
				default: begin
					bpb_q <= bpb_q;
				end
			endcase
		end
	end

	// A finished result moves into the response register whenever that
	// register is empty or being emptied in the same cycle.
	assign load       = stat.done && (!rsp_valid_q || rsp.ready);
	assign ctrl.start = req.valid && stat.idle;
	assign ctrl.taken = load;
	assign req.ready  = stat.idle;

	pbrl_engine #(
		.LEN_BITS   (LEN_BITS),
		.BUDGET_BITS(BUDGET_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.operation(req.operation),
		.now_us   (req.now_us),
		.pkt_len  (req.pkt_len),
		.bpb      (bpb_q),
		.bt       (bt_q),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_allowed_q <= stat.allowed;
			rsp_wait_q    <= stat.wait_us;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.allowed = rsp_allowed_q;
	assign rsp.wait_us = rsp_wait_q;

endmodule

// ----- rtl/pbrl_alu.sv -----
// Shared add/subtract unit with carry out; carry is set on a subtract when a >= b.
module pbrl_alu #(
	parameter int W = 64
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	logic [W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

// ----- rtl/pbrl_engine.sv -----
// Sequencer and state of the rate limiter, built around one shared adder.
`include "packet_byte_rate_limiter_core_macros.svh"

module pbrl_engine #(
	parameter int LEN_BITS    = 16,
	parameter int BUDGET_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbrl_pkg::eng_ctrl_t           ctrl,
	input  logic                          operation,
	input  logic [pbrl_pkg::TIME_W-1:0]   now_us,
	input  logic [LEN_BITS-1:0]           pkt_len,
	input  logic [BUDGET_BITS-1:0]        bpb,
	input  logic [pbrl_pkg::BT_W-1:0]     bt,
	output pbrl_pkg::eng_stat_t           stat
);

	localparam int TW     = pbrl_pkg::TIME_W;
	localparam int BTW    = pbrl_pkg::BT_W;
	localparam int WW     = pbrl_pkg::WAIT_W;
	localparam int SENT_W = BUDGET_BITS + 2;
	localparam int PROD_W = BUDGET_BITS + BTW;
	localparam int ACC_W  = (PROD_W > TW) ? PROD_W : TW;
	localparam int DQ_W   = (SENT_W > BTW) ? SENT_W : BTW;
	localparam int CNT_W  = $clog2(DQ_W + 1);

	pbrl_pkg::state_t state_q, state_d;

	logic [TW-1:0]          ws_q;
	logic [SENT_W-1:0]      sent_q;
	logic                   full_q;
	logic [ACC_W-1:0]       acc_q;
	logic [DQ_W-1:0]        dq_q;
	logic [BUDGET_BITS-1:0] rem_q;
	logic [SENT_W-1:0]      blocks_q;
	logic [BUDGET_BITS-1:0] rest_q;
	logic [TW-1:0]          tprod_q;
	logic [TW-1:0]          due_q;
	logic [TW-1:0]          diff_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [BTW-1:0]         mbt_q;
	logic [TW-1:0]          now_q;
	logic [LEN_BITS-1:0]    len_q;
	logic                   allowed_q;
	logic [WW-1:0]          wait_q;

	logic [ACC_W-1:0]       alu_a, alu_b, alu_s;
	logic                   alu_sub, alu_c;
	logic [BUDGET_BITS:0]   div_a;
	logic [BUDGET_BITS-1:0] div_rem;
	logic [DQ_W-1:0]        div_dq;
	logic [WW-1:0]          wait_sat;
	logic                   bpb_zero, bpb_ones;
	logic                   div1_last, bt_last;

	assign div_a     = {rem_q, dq_q[DQ_W-1]};
	assign div_rem   = alu_c ? alu_s[BUDGET_BITS-1:0] : div_a[BUDGET_BITS-1:0];
	assign div_dq    = {dq_q[DQ_W-2:0], alu_c};
	assign wait_sat  = (|alu_s[TW-1:WW]) ? '1 : alu_s[WW-1:0];
	assign bpb_zero  = (bpb == '0);
	assign bpb_ones  = (bpb == '1);
	assign div1_last = (cnt_q == CNT_W'(SENT_W - 1));
	assign bt_last   = (cnt_q == CNT_W'(BTW - 1));

	// Operand selection for the shared adder.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			pbrl_pkg::ST_DIV1, pbrl_pkg::ST_DIV2: begin
				alu_a   = ACC_W'(div_a);
				alu_b   = ACC_W'(bpb);
				alu_sub = 1'b1;
			end
			pbrl_pkg::ST_MUL1: begin
				alu_a = acc_q << 1;
				alu_b = mbt_q[BTW-1] ? ACC_W'(blocks_q) : '0;
			end
			pbrl_pkg::ST_MUL2: begin
				alu_a = acc_q << 1;
				alu_b = mbt_q[BTW-1] ? ACC_W'(rest_q) : '0;
			end
			pbrl_pkg::ST_DUE: begin
				alu_a = ACC_W'(tprod_q);
				alu_b = ACC_W'(dq_q[BTW-1:0]);
			end
			pbrl_pkg::ST_DIFF: begin
				alu_a   = ACC_W'(now_q);
				alu_b   = ACC_W'(ws_q);
				alu_sub = 1'b1;
			end
			pbrl_pkg::ST_CMP: begin
				alu_a   = ACC_W'(due_q);
				alu_b   = ACC_W'(diff_q);
				alu_sub = 1'b1;
			end
			pbrl_pkg::ST_MOVE: begin
				alu_a = ACC_W'(ws_q);
				alu_b = ACC_W'(tprod_q);
			end
			pbrl_pkg::ST_ADD: begin
				alu_a = ACC_W'(sent_q);
				alu_b = ACC_W'(len_q);
			end
			pbrl_pkg::ST_CHK: begin
				alu_a   = ACC_W'(sent_q);
				alu_b   = ACC_W'(bpb);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	pbrl_alu #(
		.W(ACC_W)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.sum  (alu_s),
		.carry(alu_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		stat    = '0;
		case (state_q)
			pbrl_pkg::ST_IDLE: begin
				stat.idle = 1'b1;
				if (ctrl.start) begin
					if (operation == pbrl_pkg::OP_RESTART || bpb_zero || bpb_ones) begin
						state_d = pbrl_pkg::ST_DONE;
					end else if (full_q) begin
						state_d = pbrl_pkg::ST_DIV1;
					end else begin
						state_d = pbrl_pkg::ST_ADD;
					end
				end
			end
			pbrl_pkg::ST_DIV1: begin
				if (div1_last) begin
					state_d = pbrl_pkg::ST_MUL1;
				end
			end
			pbrl_pkg::ST_MUL1: begin
				if (bt_last) begin
					state_d = pbrl_pkg::ST_MUL2;
				end
			end
			pbrl_pkg::ST_MUL2: begin
				if (bt_last) begin
					state_d = pbrl_pkg::ST_DIV2;
				end
			end
			pbrl_pkg::ST_DIV2: begin
				if (bt_last) begin
					state_d = pbrl_pkg::ST_DUE;
				end
			end
			pbrl_pkg::ST_DUE:  state_d = pbrl_pkg::ST_DIFF;
			pbrl_pkg::ST_DIFF: state_d = pbrl_pkg::ST_CMP;
			pbrl_pkg::ST_CMP: begin
				state_d = alu_c ? pbrl_pkg::ST_DONE : pbrl_pkg::ST_MOVE;
			end
			pbrl_pkg::ST_MOVE: state_d = pbrl_pkg::ST_ADD;
			pbrl_pkg::ST_ADD:  state_d = pbrl_pkg::ST_CHK;
			pbrl_pkg::ST_CHK:  state_d = pbrl_pkg::ST_DONE;
			pbrl_pkg::ST_DONE: begin
				stat.done    = 1'b1;
				stat.allowed = allowed_q;
				stat.wait_us = wait_q;
				if (ctrl.taken) begin
					state_d = pbrl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbrl_pkg::ST_IDLE;
			end
		endcase
	end

	// Limiter state proper: window start, byte count and full flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			sent_q <= '0;
			full_q <= 1'b0;
		end else begin
			case (state_q)
				pbrl_pkg::ST_IDLE: begin
					if (ctrl.start && operation == pbrl_pkg::OP_RESTART) begin
						ws_q   <= now_us;
						sent_q <= '0;
						full_q <= 1'b0;
					end
				end
				pbrl_pkg::ST_MOVE: begin
					ws_q   <= alu_s[TW-1:0];
					sent_q <= SENT_W'(rest_q);
					full_q <= 1'b0;
				end
				pbrl_pkg::ST_ADD: begin
					sent_q <= alu_s[SENT_W-1:0];
				end
				pbrl_pkg::ST_CHK: begin
					full_q <= alu_c;
				end
				default: begin
					full_q <= full_q;
				end
			endcase
		end
	end

	// Working registers of the divide and multiply iterations, the latched request and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			pbrl_pkg::ST_IDLE: begin
				now_q <= now_us;
				len_q <= pkt_len;
				rem_q <= '0;
				dq_q  <= DQ_W'(sent_q) << (DQ_W - SENT_W);
				cnt_q <= '0;
				if (ctrl.start) begin
					allowed_q <= (operation == pbrl_pkg::OP_SEND) && bpb_ones;
					wait_q    <= '0;
				end
			end
			pbrl_pkg::ST_DIV1: begin
				rem_q <= div_rem;
				dq_q  <= div_dq;
				cnt_q <= cnt_q + 1'b1;
				if (div1_last) begin
					blocks_q <= div_dq[SENT_W-1:0];
					rest_q   <= div_rem;
					acc_q    <= '0;
					mbt_q    <= bt;
					cnt_q    <= '0;
				end
			end
			pbrl_pkg::ST_MUL1: begin
				acc_q <= alu_s;
				mbt_q <= mbt_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (bt_last) begin
					tprod_q <= alu_s[TW-1:0];
					acc_q   <= '0;
					mbt_q   <= bt;
					cnt_q   <= '0;
				end
			end
			pbrl_pkg::ST_MUL2: begin
				acc_q <= alu_s;
				mbt_q <= mbt_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (bt_last) begin
					// The product over 2^20 stays below the budget, so it seeds the
					// remainder and only the low 20 bits are left to divide.
					rem_q <= alu_s[PROD_W-1:BTW];
					dq_q  <= DQ_W'(alu_s[BTW-1:0]) << (DQ_W - BTW);
					cnt_q <= '0;
				end
			end
			pbrl_pkg::ST_DIV2: begin
				rem_q <= div_rem;
				dq_q  <= div_dq;
				cnt_q <= cnt_q + 1'b1;
			end
			pbrl_pkg::ST_DUE: begin
				due_q <= alu_s[TW-1:0];
			end
			pbrl_pkg::ST_DIFF: begin
				diff_q <= alu_s[TW-1:0];
			end
			pbrl_pkg::ST_CMP: begin
				allowed_q <= 1'b0;
				wait_q    <= wait_sat;
			end
			pbrl_pkg::ST_CHK: begin
				allowed_q <= 1'b1;
				wait_q    <= '0;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	`PBRL_ASSERT_IMPL(a_start_in_idle, clk, arst_n, ctrl.start, state_q == pbrl_pkg::ST_IDLE)
	`PBRL_ASSERT_NEXT(a_done_holds, clk, arst_n, state_q == pbrl_pkg::ST_DONE && !ctrl.taken, state_q == pbrl_pkg::ST_DONE && $stable(wait_q) && $stable(allowed_q))
	`PBRL_ASSERT_IMPL(a_allowed_no_wait, clk, arst_n, state_q == pbrl_pkg::ST_DONE && allowed_q, wait_q == '0)
	`PBRL_ASSERT_IMPL(a_div_count, clk, arst_n, state_q == pbrl_pkg::ST_DIV1, cnt_q < CNT_W'(SENT_W))

endmodule

// ----- verif/packet_byte_rate_limiter_core_tb.sv -----
// Testbench of packet_byte_rate_limiter_core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module packet_byte_rate_limiter_core_tb;

	// The block is built with its default widths; the predictor keeps the same widths.
	localparam int LEN_W  = 16;
	localparam int BUD_W  = 32;
	localparam int SENT_W = BUD_W + 2;
	localparam int CFG_DW = (BUD_W > pbrl_pkg::BT_W) ? BUD_W : pbrl_pkg::BT_W;

	localparam logic [BUD_W-1:0]            BUDGET_OPEN = '1;
	localparam logic [pbrl_pkg::TIME_W-1:0] TIME_TOP    = '1;
	localparam logic [pbrl_pkg::TIME_W-1:0] WAIT_SAT    = 64'hFFFF_FFFF;

	// The watchdog limit allows for the slowest decisions and for the idling that both sides
	// may add per request, over the roughly 1325 requests of a run.
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 150;
	localparam int RANDOM_ITEMS  = 1300;

	typedef struct {
		logic                        allowed;
		logic [pbrl_pkg::WAIT_W-1:0] wait_us;
	} decision_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pbrl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DW-1:0]              cfg_data;

	pbrl_req_if #(.LEN_BITS(LEN_W)) req_ch ();
	pbrl_rsp_if rsp_ch ();

	packet_byte_rate_limiter_core #(
		.LEN_BITS(LEN_W),
		.BUDGET_BITS(BUD_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted copy of the configuration and of the window state.
	logic [BUD_W-1:0]            gate_budget;
	logic [pbrl_pkg::BT_W-1:0]   gate_block;
	logic [pbrl_pkg::TIME_W-1:0] gate_win_start;
	logic [SENT_W-1:0]           gate_sent;
	logic                        gate_full;

	// Decisions that the block still owes, oldest first.
	decision_t decision_q[$];

	// When set, neither side idles, so requests and responses run back to back.
	bit no_gaps;

	// Free-running time cursor used by the stimulus; it carries over between phases.
	logic [pbrl_pkg::TIME_W-1:0] clock_us;

	int errors;
	int n_requests;
	int n_admitted;
	int n_refused;
	int n_saturated;
	int n_settings;
	int cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Due time of the current window: whole blocks spent plus the fraction of the rest.
	// Only meaningful while the budget is neither zero nor unlimited.
	function automatic logic [pbrl_pkg::TIME_W-1:0] due_time();
		logic [pbrl_pkg::TIME_W-1:0] nblk;
		logic [pbrl_pkg::TIME_W-1:0] rest;
		nblk = 64'(gate_sent) / 64'(gate_budget);
		rest = 64'(gate_sent) % 64'(gate_budget);
		return nblk * 64'(gate_block) + (rest * 64'(gate_block)) / 64'(gate_budget);
	endfunction

	// Works out the decision for one accepted request and advances the predicted state.
	task automatic gate_predict(input logic op, input logic [pbrl_pkg::TIME_W-1:0] now,
			input logic [LEN_W-1:0] len);
		decision_t d;
		logic [pbrl_pkg::TIME_W-1:0] due;
		logic [pbrl_pkg::TIME_W-1:0] diff;
		logic [pbrl_pkg::TIME_W-1:0] nblk;
		logic pass;
		d.allowed = 1'b0;
		d.wait_us = '0;
		pass = 1'b1;
		if (op == pbrl_pkg::OP_RESTART) begin
			gate_win_start = now;
			gate_sent      = '0;
			gate_full      = 1'b0;
		end else if (gate_budget == BUDGET_OPEN) begin
			d.allowed = 1'b1;
		end else if (gate_budget != '0) begin
			if (gate_full) begin
				due  = due_time();
				diff = now - gate_win_start;
				if (diff <= due) begin
					// Too early, including exactly at the due time: report the remaining wait.
					pass      = 1'b0;
					d.wait_us = (due - diff > WAIT_SAT) ? '1 :
						pbrl_pkg::WAIT_W'(due - diff);
				end else begin
					// Late enough: slide the window by the whole blocks already spent.
					nblk           = 64'(gate_sent) / 64'(gate_budget);
					gate_win_start = gate_win_start + nblk * 64'(gate_block);
					gate_sent      = SENT_W'(64'(gate_sent) % 64'(gate_budget));
					gate_full      = 1'b0;
				end
			end
			if (pass) begin
				gate_sent = gate_sent + SENT_W'(len);
				if (64'(gate_sent) >= 64'(gate_budget))
					gate_full = 1'b1;
				d.allowed = 1'b1;
			end
		end
		decision_q.push_back(d);
	endtask

	// Offers one request, holds it until accepted and records its expected decision.
	// It returns at the accepting edge with valid still high, so a following request
	// with no gap continues without a dip in valid.
	task automatic send_req(input logic op, input logic [pbrl_pkg::TIME_W-1:0] now,
			input logic [LEN_W-1:0] len);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.now_us    <= now;
		req_ch.pkt_len   <= len;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		gate_predict(op, now, len);
		n_requests++;
	endtask

	// Stops sending and waits until every expected decision has come back. Since each
	// request gives exactly one response, the block is idle once the queue is empty; a
	// few more cycles let the sequencer settle before any register write.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (decision_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One register write; the predictor takes the new value at the same edge as the block.
	task automatic write_reg(input logic [pbrl_pkg::CFG_IDX_W-1:0] idx,
			input logic [CFG_DW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pbrl_pkg::CFG_IDX_BUDGET) begin
			gate_budget = val[BUD_W-1:0];
			n_settings++;
		end else begin
			gate_block = val[pbrl_pkg::BT_W-1:0];
		end
		@(posedge clk);
	endtask

	// Response side: draws a stall for every response, then checks it against the oldest
	// expectation. Values are read right after the edge, so they are the ones the edge saw.
	initial begin : rsp_sink
		int stall;
		decision_t want;
		rsp_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			if (decision_q.size() == 0) begin
				$error("unexpected response: allowed %0d, wait_us %0d",
					rsp_ch.allowed, rsp_ch.wait_us);
				errors++;
			end else begin
				want = decision_q.pop_front();
				if (rsp_ch.allowed !== want.allowed) begin
					$error("allowed: expected %0d, actual %0d", want.allowed, rsp_ch.allowed);
					errors++;
				end
				if (rsp_ch.wait_us !== want.wait_us) begin
					$error("wait_us: expected %0d, actual %0d", want.wait_us, rsp_ch.wait_us);
					errors++;
				end
				if (want.allowed)
					n_admitted++;
				else
					n_refused++;
				if (want.wait_us == '1)
					n_saturated++;
			end
		end
	end

	// Out of reset the budget is zero, so every send is refused without a wait.
	// Restart and the all-ones time and length are covered here as well.
	task automatic test_defaults();
		send_req(pbrl_pkg::OP_SEND, '0, '0);
		send_req(pbrl_pkg::OP_RESTART, TIME_TOP, '1);
		send_req(pbrl_pkg::OP_SEND, TIME_TOP, '1);
	endtask

	// An all-ones budget admits every packet whatever the time and length.
	task automatic test_unlimited();
		wait_idle();
		write_reg(pbrl_pkg::CFG_IDX_BUDGET, CFG_DW'(BUDGET_OPEN));
		write_reg(pbrl_pkg::CFG_IDX_BLOCK, CFG_DW'(pbrl_pkg::BT_RESET));
		send_req(pbrl_pkg::OP_SEND, '0, '1);
		send_req(pbrl_pkg::OP_SEND, TIME_TOP, '0);
	endtask

	// Spend the budget, then ask before, exactly at and just after the due time.
	task automatic test_due_time();
		wait_idle();
		write_reg(pbrl_pkg::CFG_IDX_BUDGET, 1000);
		write_reg(pbrl_pkg::CFG_IDX_BLOCK, 1000);
		send_req(pbrl_pkg::OP_RESTART, 64'd0, LEN_W'(0));
		send_req(pbrl_pkg::OP_SEND, 64'd0, LEN_W'(1000));
		send_req(pbrl_pkg::OP_SEND, 64'd500, LEN_W'(7));
		send_req(pbrl_pkg::OP_SEND, 64'd1000, LEN_W'(7));
		send_req(pbrl_pkg::OP_SEND, 64'd1001, LEN_W'(1));
		send_req(pbrl_pkg::OP_SEND, 64'd1001, LEN_W'(0));
	endtask

	// A one-byte budget with a full packet and a one-second block gives a wait that
	// does not fit in 32 bits, so it must saturate.
	task automatic test_saturation();
		wait_idle();
		write_reg(pbrl_pkg::CFG_IDX_BUDGET, 1);
		write_reg(pbrl_pkg::CFG_IDX_BLOCK, CFG_DW'(pbrl_pkg::BT_RESET));
		send_req(pbrl_pkg::OP_RESTART, 64'd5, LEN_W'(0));
		send_req(pbrl_pkg::OP_SEND, 64'd5, '1);
		send_req(pbrl_pkg::OP_SEND, 64'd6, LEN_W'(0));
	endtask

	// The window starts just below the top of the time range; the difference is
	// taken modulo 2^64, and a time just before the window start looks very late.
	task automatic test_time_wrap();
		wait_idle();
		write_reg(pbrl_pkg::CFG_IDX_BUDGET, 100);
		write_reg(pbrl_pkg::CFG_IDX_BLOCK, 50);
		send_req(pbrl_pkg::OP_RESTART, TIME_TOP - 64'd9, LEN_W'(0));
		send_req(pbrl_pkg::OP_SEND, TIME_TOP - 64'd9, LEN_W'(100));
		send_req(pbrl_pkg::OP_SEND, 64'd30, LEN_W'(3));
		send_req(pbrl_pkg::OP_SEND, TIME_TOP - 64'd10, LEN_W'(3));
	endtask

	// Raising the budget while the full flag is set keeps the count; with a block time
	// of one microsecond the due time rounds to zero.
	task automatic test_budget_change();
		wait_idle();
		write_reg(pbrl_pkg::CFG_IDX_BUDGET, 1000);
		write_reg(pbrl_pkg::CFG_IDX_BLOCK, 1);
		send_req(pbrl_pkg::OP_RESTART, 64'd0, LEN_W'(0));
		send_req(pbrl_pkg::OP_SEND, 64'd0, LEN_W'(1500));
		wait_idle();
		write_reg(pbrl_pkg::CFG_IDX_BUDGET, 3000);
		send_req(pbrl_pkg::OP_SEND, 64'd0, LEN_W'(2));
		send_req(pbrl_pkg::OP_SEND, 64'd1, LEN_W'(2));
	endtask

	// Random phases: each picks a budget and a block time, mostly restarts the window,
	// then walks time forward in steps near the block time so that the budget fills and
	// requests land both before and after the due time. Some requests hit the due time
	// to within one microsecond, a few restart mid-phase and a few carry random times.
	task automatic test_random(input int target);
		int done_n;
		int phase_n;
		int pick;
		int len_cap;
		logic [pbrl_pkg::TIME_W-1:0] step;
		logic [LEN_W-1:0] len;
		done_n = 0;
		clock_us = '0;
		while (done_n < target) begin
			wait_idle();
			pick = $urandom_range(0, 19);
			case (pick)
				0: write_reg(pbrl_pkg::CFG_IDX_BUDGET, '0);
				1: write_reg(pbrl_pkg::CFG_IDX_BUDGET, CFG_DW'(BUDGET_OPEN));
				2: write_reg(pbrl_pkg::CFG_IDX_BUDGET, 1);
				3: write_reg(pbrl_pkg::CFG_IDX_BUDGET, CFG_DW'(BUDGET_OPEN - 1'b1));
				4: write_reg(pbrl_pkg::CFG_IDX_BUDGET, CFG_DW'($urandom));
				5, 6, 7, 8, 9: write_reg(pbrl_pkg::CFG_IDX_BUDGET, $urandom_range(1, 4096));
				default: write_reg(pbrl_pkg::CFG_IDX_BUDGET, $urandom_range(4096, 300000));
			endcase
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: write_reg(pbrl_pkg::CFG_IDX_BLOCK, 1);
					1: write_reg(pbrl_pkg::CFG_IDX_BLOCK, CFG_DW'(pbrl_pkg::BT_RESET));
					2: write_reg(pbrl_pkg::CFG_IDX_BLOCK, $urandom_range(1, 1000000));
					default: write_reg(pbrl_pkg::CFG_IDX_BLOCK, $urandom_range(1, 5000));
				endcase
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0, 1: clock_us = {$urandom, $urandom};
				2: clock_us = TIME_TOP - 64'($urandom_range(0, 4 * int'(gate_block)));
				default: ;
			endcase
			// Most phases restart; the others keep counting under the new budget.
			if ($urandom_range(0, 4) != 0) begin
				send_req(pbrl_pkg::OP_RESTART, clock_us, LEN_W'($urandom));
				done_n++;
			end
			case ($urandom_range(0, 2))
				0: len_cap = 255;
				1: len_cap = 4095;
				default: len_cap = 65535;
			endcase
			phase_n = $urandom_range(20, 60);
			repeat (phase_n) begin
				len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) :
					LEN_W'($urandom_range(0, len_cap));
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send_req(pbrl_pkg::OP_RESTART, clock_us, len);
				end else if (pick < 10) begin
					send_req(pbrl_pkg::OP_SEND, {$urandom, $urandom}, len);
				end else if (pick < 30 && gate_full && gate_budget != '0 &&
						gate_budget != BUDGET_OPEN) begin
					// One microsecond before, at, or one after the due time.
					clock_us = gate_win_start + due_time() + 64'($urandom_range(0, 2)) - 64'd1;
					send_req(pbrl_pkg::OP_SEND, clock_us, len);
				end else begin
					case ($urandom_range(0, 7))
						0: step = '0;
						1: step = 64'($urandom_range(0, 3));
						6: step = 64'($urandom_range(0, 8 * int'(gate_block)));
						7: step = 64'($urandom);
						default: step = 64'($urandom_range(0, int'(gate_block)));
					endcase
					clock_us = clock_us + step;
					send_req(pbrl_pkg::OP_SEND, clock_us, len);
				end
				done_n++;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin : stimulus
		n_requests  = 0;
		n_settings  = 0;
		no_gaps     = 1'b0;

		// Reset state of the predictor matches the block's reset values.
		gate_budget    = '0;
		gate_block     = pbrl_pkg::BT_RESET;
		gate_win_start = '0;
		gate_sent      = '0;
		gate_full      = 1'b0;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= pbrl_pkg::CFG_IDX_BUDGET;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= pbrl_pkg::OP_SEND;
		req_ch.now_us    <= '0;
		req_ch.pkt_len   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_unlimited();
		test_due_time();
		test_saturation();
		test_time_wrap();
		test_budget_change();
		test_random(RANDOM_ITEMS);

		// Let the last decisions drain, then watch a while for stray responses.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (decision_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d budget settings: %0d admitted, %0d refused.",
			n_requests, n_settings, n_admitted, n_refused);
		$display("Refusals with a saturated wait: %0d; mismatches: %0d.", n_saturated, errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pbrl_pkg.sv
rtl/pbrl_if.sv
rtl/pbrl_alu.sv
rtl/pbrl_engine.sv
rtl/packet_byte_rate_limiter_core.sv
verif/packet_byte_rate_limiter_core_tb.sv
